// File: hw/rtl/rbd_pkg.sv
// Shared types and constants for the RGBA16 box downsampler.
// Used by every module of the block except rbd_ram, and by its checker.
package rbd_pkg;

    // Channel and lane layout
    localparam int CH_BITS    = 16;
    localparam int NUM_LANES  = 4;

    // Geometry limits
    localparam int MAX_WIDTH_LOG2 = 12;
    localparam int MAX_RATIO_LOG2 = 4;
    localparam int POS_BITS       = MAX_WIDTH_LOG2;
    localparam int LINE_DEPTH     = 1 << MAX_WIDTH_LOG2;
    localparam int BLK_BITS       = MAX_RATIO_LOG2;
    localparam int SHIFT_BITS     = $clog2(2 * MAX_RATIO_LOG2 + 1);

    // Accumulator widths: one block row, then a whole block
    localparam int ROW_BITS  = CH_BITS + MAX_RATIO_LOG2;
    localparam int LINE_BITS = CH_BITS + 2 * MAX_RATIO_LOG2;

    // Configuration register fields
    localparam int WL_BITS  = 4;
    localparam int RL_BITS  = 3;
    localparam int CFG_DATA = 32;
    localparam int CFG_ADDR = 4;
    localparam int REG_IDX_BITS = 2;

    localparam logic [REG_IDX_BITS-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_RATIO_X    = 2'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_RATIO_Y    = 2'd3;

    localparam logic [WL_BITS-1:0] RST_SRC_LOG2   = 4'd8;
    localparam logic [RL_BITS-1:0] RST_RATIO_LOG2 = 3'd1;

    // Output queue
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_BITS = 2;
    localparam int Q_CNT_BITS = 3;

    // Per-pixel control that walks down the lane pipeline
    typedef struct packed {
        logic                    valid;
        logic                    row_first;
        logic                    row_last;
        logic                    col_first;
        logic                    col_last;
        logic                    frame_end;
        logic [POS_BITS-1:0]     addr;
        logic [SHIFT_BITS-1:0]   shift;
    } ctl_t;

    typedef logic [NUM_LANES-1:0][CH_BITS-1:0] pix_t;

    typedef struct packed {
        logic frame_end;
        pix_t pix;
    } result_t;

endpackage

// File: hw/rtl/rbd_ram.sv
// Generic simple dual-port RAM with registered read.
// No package dependency; one write port and one read port.
module rbd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read, old data on a same-address write
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/rbd_lane.sv
// One channel lane: block-row accumulator, column-sum line store and mean.
// Depends on rbd_pkg and rbd_ram.
module rbd_lane
    import rbd_pkg::*;
(
    input  logic                aclk,
    input  ctl_t                ctl0,
    input  ctl_t                ctl1,
    input  logic [CH_BITS-1:0]  sample,
    output logic [CH_BITS-1:0]  mean
);

    logic [ROW_BITS-1:0]  row_sum_reg, row_sum_next;
    logic [ROW_BITS-1:0]  acc_reg;
    logic [ROW_BITS-1:0]  row_base, acc;
    logic                 fwd_hit_reg;
    logic [LINE_BITS-1:0] fwd_data_reg;
    logic [LINE_BITS-1:0] rdata, line_val, col_sum, shifted;
    logic                 wr;

    // Stage 0: extend the running sum across the block row
    always_comb begin
        row_base = ctl0.row_first ? '0 : row_sum_reg;
        acc      = row_base + ROW_BITS'(sample);
        row_sum_next = row_sum_reg;
        if (ctl0.valid) begin
            row_sum_next = ctl0.row_last ? '0 : acc;
        end
    end

    always_ff @(posedge aclk) begin
        row_sum_reg <= row_sum_next;
        if (ctl0.valid) begin
            acc_reg <= acc;
        end
    end

    // Column sums per destination column
    rbd_ram #(
        .WIDTH (LINE_BITS),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .aclk  (aclk),
        .we    (wr),
        .waddr (ctl1.addr),
        .wdata (col_sum),
        .re    (ctl0.valid && ctl0.row_last),
        .raddr (ctl0.addr),
        .rdata (rdata)
    );

    // Stage 1: add the block row to its column, store or average
    always_comb begin
        wr       = ctl1.valid && ctl1.row_last && !ctl1.col_last;
        line_val = fwd_hit_reg ? fwd_data_reg : rdata;
        col_sum  = (ctl1.col_first ? '0 : line_val) + LINE_BITS'(acc_reg);
        shifted  = col_sum >> ctl1.shift;
        mean     = shifted[CH_BITS-1:0];
    end

    // Bypass a column sum written in the same cycle it is read
    always_ff @(posedge aclk) begin
        fwd_hit_reg  <= wr && (ctl1.addr == ctl0.addr);
        fwd_data_reg <= col_sum;
    end

endmodule

// File: hw/rtl/rbd_outq.sv
// Output queue: holds merged result items until the output port takes them.
// Depends on rbd_pkg.
module rbd_outq
    import rbd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  result_t               push_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output result_t               head,
    output logic [Q_CNT_BITS-1:0] count
);

    result_t                 q_reg [Q_DEPTH];
    logic [Q_PTR_BITS-1:0]   wptr_reg, wptr_next;
    logic [Q_PTR_BITS-1:0]   rptr_reg, rptr_next;
    logic [Q_CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                    pop;

    // Pointer and fill bookkeeping
    always_comb begin
        pop       = m_valid && m_ready;
        wptr_next = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = pop  ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg + Q_CNT_BITS'(push) - Q_CNT_BITS'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wptr_reg] <= push_data;
        end
    end

    assign m_valid = (cnt_reg != '0);
    assign head    = q_reg[rptr_reg];
    assign count   = cnt_reg;

endmodule

// File: hw/rtl/rgba16_box_downsampler.sv
// Top level of the RGBA16 box downsampler: registers, position counters,
// lane control and output. Depends on rbd_pkg, rbd_lane and rbd_outq.
//
//  Port group   Dir   Payload
//  s_*          in    tdata: in_red, in_green, in_blue, in_alpha (16 b each)
//  m_*          out   tdata: out_red..out_alpha (16 b each), tlast: frame_end
//  p*           cfg   APB: 0 src_width_log2, 4 src_height_log2,
//                          8 ratio_x_log2, 12 ratio_y_log2
//
// One pixel per clock while s_tready is high. The block-row add runs in the cycle a
// pixel is accepted; the line-store read and column add run in the next cycle, and a
// finished block is then written into the output queue, from whose head it leaves.
// The four-entry output queue keeps s_tready high while m_tready is low
// until the queue and the pixel in flight could fill it.
// Reset is synchronous; no clearing pass, the line store is written in
// each frame before it is read. Any register write restarts the frame.
module rgba16_box_downsampler
    import rbd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // source pixels
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [63:0]          s_tdata,   // in_red, in_green, in_blue, in_alpha
    // destination pixels
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [63:0]          m_tdata,   // out_red, out_green, out_blue, out_alpha
    output logic                 m_tlast,   // frame_end
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [CFG_ADDR-1:0]  paddr,
    input  logic [CFG_DATA-1:0]  pwdata,
    output logic [CFG_DATA-1:0]  prdata,
    output logic                 pready
);

    logic [WL_BITS-1:0]    src_w_reg, src_h_reg;
    logic [RL_BITS-1:0]    ratio_x_reg, ratio_y_reg;
    logic [POS_BITS-1:0]   col_x_reg, col_x_next;
    logic [POS_BITS-1:0]   row_y_reg, row_y_next;
    logic                  cfg_wr;
    logic [REG_IDX_BITS-1:0] cfg_idx;

    logic [WL_BITS-1:0]    wl, hl;
    logic [RL_BITS-1:0]    rxs, rys, rx, ry;
    logic [POS_BITS-1:0]   wmask, hmask, x, y;
    logic [BLK_BITS-1:0]   bxmask, bymask, bx, by;
    logic                  accept, x_last, y_last;

    ctl_t                  ctl0, ctl1_reg;
    pix_t                  px, means;
    result_t               res, head;
    logic                  push;
    logic [Q_CNT_BITS-1:0] q_count;

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[CFG_ADDR-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_w_reg   <= RST_SRC_LOG2;
            src_h_reg   <= RST_SRC_LOG2;
            ratio_x_reg <= RST_RATIO_LOG2;
            ratio_y_reg <= RST_RATIO_LOG2;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_SRC_WIDTH:  src_w_reg   <= pwdata[WL_BITS-1:0];
                REG_SRC_HEIGHT: src_h_reg   <= pwdata[WL_BITS-1:0];
                REG_RATIO_X:    ratio_x_reg <= pwdata[RL_BITS-1:0];
                REG_RATIO_Y:    ratio_y_reg <= pwdata[RL_BITS-1:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_SRC_WIDTH:  prdata = CFG_DATA'(src_w_reg);
            REG_SRC_HEIGHT: prdata = CFG_DATA'(src_h_reg);
            REG_RATIO_X:    prdata = CFG_DATA'(ratio_x_reg);
            REG_RATIO_Y:    prdata = CFG_DATA'(ratio_y_reg);
            default:        prdata = '0;
        endcase
    end

    // Saturate sizes and ratios
    always_comb begin
        wl  = (src_w_reg > WL_BITS'(MAX_WIDTH_LOG2)) ? WL_BITS'(MAX_WIDTH_LOG2) : src_w_reg;
        hl  = (src_h_reg > WL_BITS'(MAX_WIDTH_LOG2)) ? WL_BITS'(MAX_WIDTH_LOG2) : src_h_reg;
        rxs = (ratio_x_reg > RL_BITS'(MAX_RATIO_LOG2)) ? RL_BITS'(MAX_RATIO_LOG2)
                                                        : ratio_x_reg;
        rys = (ratio_y_reg > RL_BITS'(MAX_RATIO_LOG2)) ? RL_BITS'(MAX_RATIO_LOG2)
                                                        : ratio_y_reg;
        rx  = (WL_BITS'(rxs) > wl) ? wl[RL_BITS-1:0] : rxs;
        ry  = (WL_BITS'(rys) > hl) ? hl[RL_BITS-1:0] : rys;
    end

    // Position within the frame and within the block
    always_comb begin
        wmask  = ~({POS_BITS{1'b1}} << wl);
        hmask  = ~({POS_BITS{1'b1}} << hl);
        bxmask = ~({BLK_BITS{1'b1}} << rx);
        bymask = ~({BLK_BITS{1'b1}} << ry);
        x      = col_x_reg & wmask;
        y      = row_y_reg & hmask;
        bx     = x[BLK_BITS-1:0] & bxmask;
        by     = y[BLK_BITS-1:0] & bymask;
        x_last = (x == wmask);
        y_last = (y == hmask);
    end

    // Hold off input while queue plus the pixel in flight could fill it
    assign push     = ctl1_reg.valid && ctl1_reg.row_last && ctl1_reg.col_last;
    assign s_tready = (Q_CNT_BITS'(q_count) + Q_CNT_BITS'(push)) < Q_CNT_BITS'(Q_DEPTH);
    assign accept   = s_tvalid && s_tready;

    // Build the lane control for the accepted pixel
    always_comb begin
        ctl0.valid     = accept;
        ctl0.row_first = (bx == '0);
        ctl0.row_last  = (bx == bxmask);
        ctl0.col_first = (by == '0);
        ctl0.col_last  = (by == bymask);
        ctl0.frame_end = x_last && y_last;
        ctl0.addr      = x >> rx;
        ctl0.shift     = SHIFT_BITS'(rx) + SHIFT_BITS'(ry);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
        end else begin
            ctl1_reg <= ctl0;
        end
    end

    // Advance the raster position; a register write restarts the frame
    always_comb begin
        col_x_next = col_x_reg;
        row_y_next = row_y_reg;
        priority if (cfg_wr) begin
            col_x_next = '0;
            row_y_next = '0;
        end else if (accept) begin
            col_x_next = x_last ? '0 : x + 1'b1;
            row_y_next = x_last ? (y_last ? '0 : y + 1'b1) : y;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_x_reg <= '0;
            row_y_reg <= '0;
        end else begin
            col_x_reg <= col_x_next;
            row_y_reg <= row_y_next;
        end
    end

    // Channel lanes
    assign px = s_tdata;

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        rbd_lane u_lane (
            .aclk   (aclk),
            .ctl0   (ctl0),
            .ctl1   (ctl1_reg),
            .sample (px[i]),
            .mean   (means[i])
        );
    end

    // Merge lanes into one result item
    assign res.pix       = means;
    assign res.frame_end = ctl1_reg.frame_end;

    rbd_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (res),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .head      (head),
        .count     (q_count)
    );

    assign m_tdata = head.pix;
    assign m_tlast = head.frame_end;

endmodule

// File: hw/rtl/rbd_checker.sv
// Port-level checker for the RGBA16 box downsampler, bound to the top.
// Depends on rbd_pkg.
module rbd_checker
    import rbd_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tlast
);

    // A stalled result item stays offered
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    // A stalled result item keeps its payload
    a_m_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable({m_tlast, m_tdata}))
        else $error("result payload changed while stalled");

    // Reset empties the output side
    a_rst_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result item present after reset");

    // A new result item follows a taken pixel through the lane control register and the queue
    a_m_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result item without a source pixel");

    // Input stays open while the output queue is empty
    a_full_rate: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind rgba16_box_downsampler rbd_checker u_rbd_checker (.*);

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for rgba16_box_downsampler: streams RGBA16 pixels in raster order
// through several geometries and compares every block mean against its own predictor.
// Depends on rbd_pkg and the block's RTL only.
module testbench
    import rbd_pkg::*;
();

    // Predicts the block means and holds those not yet seen on the output
    class box_mean_scoreboard;
        logic [WL_BITS-1:0]   width_log2;
        logic [WL_BITS-1:0]   height_log2;
        logic [RL_BITS-1:0]   ratio_x_log2;
        logic [RL_BITS-1:0]   ratio_y_log2;
        int unsigned          col_pos;
        int unsigned          row_pos;
        logic [ROW_BITS-1:0]  block_row_sum [NUM_LANES];
        logic [LINE_BITS-1:0] column_sums [NUM_LANES][LINE_DEPTH];
        result_t              pending_means [$];
        int unsigned          mismatches;
        int unsigned          means_checked;

        function new();
            width_log2    = RST_SRC_LOG2;
            height_log2   = RST_SRC_LOG2;
            ratio_x_log2  = RST_RATIO_LOG2;
            ratio_y_log2  = RST_RATIO_LOG2;
            col_pos       = 0;
            row_pos       = 0;
            mismatches    = 0;
            means_checked = 0;
            foreach (block_row_sum[l]) block_row_sum[l] = '0;
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10) $display("MISMATCH: %s", msg);
        endfunction

        // Any register write restarts the frame
        function void write_reg(logic [REG_IDX_BITS-1:0] idx, logic [CFG_DATA-1:0] value);
            case (idx)
                REG_SRC_WIDTH:  width_log2   = value[WL_BITS-1:0];
                REG_SRC_HEIGHT: height_log2  = value[WL_BITS-1:0];
                REG_RATIO_X:    ratio_x_log2 = value[RL_BITS-1:0];
                REG_RATIO_Y:    ratio_y_log2 = value[RL_BITS-1:0];
                default: ;
            endcase
            col_pos = 0;
            row_pos = 0;
        endfunction

        function logic [CFG_DATA-1:0] reg_value(logic [REG_IDX_BITS-1:0] idx);
            case (idx)
                REG_SRC_WIDTH:  return CFG_DATA'(width_log2);
                REG_SRC_HEIGHT: return CFG_DATA'(height_log2);
                REG_RATIO_X:    return CFG_DATA'(ratio_x_log2);
                default:        return CFG_DATA'(ratio_y_log2);
            endcase
        endfunction

        // Accumulate one accepted source pixel, queue a mean when a block completes
        function void note_source_pixel(pix_t p);
            int unsigned          wl, hl, rx, ry;
            int unsigned          wmask, hmask, bxmask, bymask;
            int unsigned          x, y, bx, by, dcol;
            logic [ROW_BITS-1:0]  acc;
            logic [LINE_BITS-1:0] col_sum;
            result_t              res;
            bit                   emit;

            wl = (width_log2 > MAX_WIDTH_LOG2) ? MAX_WIDTH_LOG2 : width_log2;
            hl = (height_log2 > MAX_WIDTH_LOG2) ? MAX_WIDTH_LOG2 : height_log2;
            rx = (ratio_x_log2 > MAX_RATIO_LOG2) ? MAX_RATIO_LOG2 : ratio_x_log2;
            ry = (ratio_y_log2 > MAX_RATIO_LOG2) ? MAX_RATIO_LOG2 : ratio_y_log2;
            if (rx > wl) rx = wl;
            if (ry > hl) ry = hl;
            wmask  = (1 << wl) - 1;
            hmask  = (1 << hl) - 1;
            bxmask = (1 << rx) - 1;
            bymask = (1 << ry) - 1;
            x    = col_pos & wmask;
            y    = row_pos & hmask;
            bx   = x & bxmask;
            by   = y & bymask;
            dcol = (x >> rx) & (LINE_DEPTH - 1);
            res  = '0;
            emit = 0;

            for (int l = 0; l < NUM_LANES; l++) begin
                if (bx == 0) acc = ROW_BITS'(p[l]);
                else acc = block_row_sum[l] + ROW_BITS'(p[l]);
                if (bx == bxmask) begin
                    if (by == 0) col_sum = LINE_BITS'(acc);
                    else col_sum = column_sums[l][dcol] + LINE_BITS'(acc);
                    if (by == bymask) begin
                        res.pix[l] = CH_BITS'(col_sum >> (rx + ry));
                        emit = 1;
                    end else begin
                        column_sums[l][dcol] = col_sum;
                    end
                    block_row_sum[l] = '0;
                end else begin
                    block_row_sum[l] = acc;
                end
            end
            if (emit) begin
                res.frame_end = (x == wmask) && (y == hmask);
                pending_means.push_back(res);
            end

            // Advance the raster position, wrapping at frame end
            if (x == wmask) begin
                col_pos = 0;
                row_pos = (y == hmask) ? 0 : y + 1;
            end else begin
                col_pos = x + 1;
                row_pos = y;
            end
        endfunction

        // Compare one accepted destination pixel with the oldest pending mean
        function void check_dest_pixel(pix_t data, logic last);
            result_t want;
            string   lane_name [NUM_LANES] = '{"red", "green", "blue", "alpha"};

            if (pending_means.size() == 0) begin
                report($sformatf("unexpected result %h last %b", data, last));
                return;
            end
            want = pending_means.pop_front();
            means_checked++;
            for (int l = 0; l < NUM_LANES; l++) begin
                if (data[l] !== want.pix[l])
                    report($sformatf("result %0d %s expected %h got %h",
                                     means_checked, lane_name[l], want.pix[l], data[l]));
            end
            if (last !== want.frame_end)
                report($sformatf("result %0d frame_end expected %b got %b",
                                 means_checked, want.frame_end, last));
        endfunction
    endclass

    localparam int ITEM_TARGET = 550;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [63:0]          s_tdata;   // in_red, in_green, in_blue, in_alpha
    logic                 m_tvalid;
    logic                 m_tready;
    logic [63:0]          m_tdata;   // out_red, out_green, out_blue, out_alpha
    logic                 m_tlast;   // frame_end
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [CFG_ADDR-1:0]  paddr;
    logic [CFG_DATA-1:0]  pwdata;
    logic [CFG_DATA-1:0]  prdata;
    logic                 pready;

    box_mean_scoreboard sb = new();

    int src_idle_mode;
    int sink_stall_mode;
    int stall_left = 0;
    int pixels_sent;
    int settings_used;

    rgba16_box_downsampler u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Hard stop if the run hangs
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Stall the result channel: short stalls mostly, a long one now and then
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready = 1'b0;
        end else if (sink_stall_mode != 0 &&
                     $urandom_range(0, 99) < (sink_stall_mode == 1 ? 15 : 40)) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 2);
            m_tready = 1'b0;
        end else begin
            m_tready = 1'b1;
        end
    end

    // Check every accepted result
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_dest_pixel(m_tdata, m_tlast);
    end

    function automatic int pick_gap();
        int r;
        if (src_idle_mode == 0) return 0;
        r = $urandom_range(0, 99);
        if (r < (src_idle_mode == 1 ? 75 : 40)) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic pix_t random_pixel();
        pix_t p;
        for (int l = 0; l < NUM_LANES; l++) begin
            case ($urandom_range(0, 7))
                0:       p[l] = '1;
                1:       p[l] = '0;
                default: p[l] = CH_BITS'($urandom);
            endcase
        end
        return p;
    endfunction

    // Offer one pixel after a random gap; returns at the falling edge after acceptance
    task automatic send_pixel(input pix_t p);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = p;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_source_pixel(p);
        pixels_sent++;
        @(negedge aclk);
    endtask

    task automatic apb_write(input logic [REG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.write_reg(idx, value);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_read_check(input logic [REG_IDX_BITS-1:0] idx);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== sb.reg_value(idx))
            sb.report($sformatf("register %0d read expected %h got %h",
                                idx, sb.reg_value(idx), prdata));
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Hold off until all means are out and the pipeline has settled
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (sb.pending_means.size() != 0) @(negedge aclk);
        repeat (12) @(negedge aclk);
    endtask

    task automatic read_all_regs();
        apb_read_check(REG_SRC_WIDTH);
        apb_read_check(REG_SRC_HEIGHT);
        apb_read_check(REG_RATIO_X);
        apb_read_check(REG_RATIO_Y);
    endtask

    // Write all four registers, sometimes with junk in the unused upper bits
    task automatic set_geometry(input int w, input int h, input int rx, input int ry);
        logic [CFG_DATA-1:0] junk;
        wait_idle();
        junk = ($urandom_range(0, 2) == 0) ? ($urandom & 32'hFFFF_FFF0) : '0;
        apb_write(REG_SRC_WIDTH,  junk | CFG_DATA'(w));
        apb_write(REG_SRC_HEIGHT, junk | CFG_DATA'(h));
        junk = junk & 32'hFFFF_FFF8;
        apb_write(REG_RATIO_X,    junk | CFG_DATA'(rx));
        apb_write(REG_RATIO_Y,    junk | CFG_DATA'(ry));
        read_all_regs();
        settings_used++;
    endtask

    // One random geometry; sends at most budget pixels
    task automatic run_random_phase(input int unsigned budget);
        int          w, h, rx, ry;
        int unsigned wl, hl, frame, count;
        int          kind;

        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            // wide rows, one block row high
            w  = $urandom_range(12, 15);
            h  = $urandom_range(0, 15);
            rx = $urandom_range(0, 7);
            ry = 0;
        end else if (kind == 1) begin
            // tall and narrow
            w  = $urandom_range(0, 1);
            h  = $urandom_range(12, 15);
            rx = $urandom_range(0, 7);
            ry = $urandom_range(0, 7);
        end else begin
            w  = $urandom_range(0, 4);
            h  = $urandom_range(0, 4);
            rx = $urandom_range(0, 7);
            ry = $urandom_range(0, 7);
        end

        src_idle_mode   = $urandom_range(0, 2);
        sink_stall_mode = $urandom_range(0, 2);

        if ($urandom_range(0, 3) == 0) begin
            // rewrite one register unchanged: only restarts the frame
            wait_idle();
            apb_write(REG_RATIO_Y, sb.reg_value(REG_RATIO_Y));
            w = sb.width_log2;
            h = sb.height_log2;
        end else begin
            set_geometry(w, h, rx, ry);
        end

        wl = (w > MAX_WIDTH_LOG2) ? MAX_WIDTH_LOG2 : w;
        hl = (h > MAX_WIDTH_LOG2) ? MAX_WIDTH_LOG2 : h;
        frame = 1 << (wl + hl);
        if (frame <= 64) count = frame * $urandom_range(1, 3);
        else count = $urandom_range(16, 96);
        // now and then stop in the middle of a frame
        if ($urandom_range(0, 4) == 0) count = $urandom_range(1, (frame < 96) ? frame : 96);
        if (count > budget) count = budget;

        repeat (count) send_pixel(random_pixel());
    endtask

    initial begin
        pix_t all_ones;

        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        src_idle_mode   = 0;
        sink_stall_mode = 0;
        pixels_sent     = 0;
        settings_used   = 0;
        all_ones        = '1;

        repeat (9) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Reset values of the registers
        read_all_regs();

        // 2x2 frame, 2x2 blocks: full scale, then zero
        set_geometry(1, 1, 1, 1);
        repeat (4) send_pixel(all_ones);
        repeat (4) send_pixel('0);

        // Oversized ratios saturate to the source size
        src_idle_mode   = 1;
        sink_stall_mode = 2;
        set_geometry(2, 1, 7, 7);
        repeat (8) send_pixel(random_pixel());

        // Oversized size registers saturate to the line store size
        set_geometry(15, 15, 2, 0);
        repeat (4) send_pixel(all_ones);

        // 1x1 frame, no shrink: every pixel passes through and ends a frame
        src_idle_mode   = 0;
        sink_stall_mode = 0;
        set_geometry(0, 0, 0, 0);
        repeat (3) send_pixel(random_pixel());

        // Random geometries and content
        while (pixels_sent < ITEM_TARGET)
            run_random_phase(ITEM_TARGET - pixels_sent);

        // Drain and settle
        s_tvalid = 1'b0;
        while (sb.pending_means.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (sb.pending_means.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending_means.size()));

        $display("Sent %0d source pixels over %0d register settings (saturated sizes,",
                 pixels_sent, settings_used);
        $display("ratios and partial frames included); checked %0d averaged pixels.",
                 sb.means_checked);
        if (sb.mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
